// ===== hw/rtl/vsp_pkg.sv =====
package vsp_pkg;

  localparam int CharBits     = 8;
  localparam int NumberBits   = 64;
  localparam int ErrorBits    = 3;
  localparam int BuildPosBits = 16;
  localparam int PrefixBits   = 3;
  localparam int PrefixLength = 5;
  localparam int DigitBits    = 4;

  localparam int PositionBitsDefault = 16;

  localparam logic [BuildPosBits-1:0] BuildStartMax = '1;

  // Error codes reported with each result word.
  localparam logic [ErrorBits-1:0] ERR_NONE      = 3'd0;
  localparam logic [ErrorBits-1:0] ERR_MAJOR     = 3'd1;
  localparam logic [ErrorBits-1:0] ERR_NO_DOT    = 3'd2;
  localparam logic [ErrorBits-1:0] ERR_MINOR     = 3'd3;
  localparam logic [ErrorBits-1:0] ERR_PATCH     = 3'd4;
  localparam logic [ErrorBits-1:0] ERR_RC_FORMAT = 3'd5;
  localparam logic [ErrorBits-1:0] ERR_RC_NUMBER = 3'd6;
  localparam logic [ErrorBits-1:0] ERR_BUILD     = 3'd7;

  localparam logic [CharBits-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharBits-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CharBits-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CharBits-1:0] CHAR_DASH  = 8'h2D;
  localparam logic [CharBits-1:0] CHAR_R     = 8'h72;
  localparam logic [CharBits-1:0] CHAR_C     = 8'h63;
  localparam logic [CharBits-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CharBits-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CharBits-1:0] CHAR_CR    = 8'h0D;

  typedef struct packed {
    logic [CharBits-1:0] character;
    logic                final_char;
  } char_word_t;

  typedef struct packed {
    logic [ErrorBits-1:0]    error_code;
    logic [NumberBits-1:0]   major_version;
    logic [NumberBits-1:0]   minor_version;
    logic [NumberBits-1:0]   patch_version;
    logic [NumberBits-1:0]   candidate_number;
    logic                    has_build_text;
    logic [BuildPosBits-1:0] build_start;
  } result_word_t;

  // Characters of the optional product prefix, by position.
  function automatic logic [CharBits-1:0] prefix_char(input logic [PrefixBits-1:0] idx);
    logic [CharBits-1:0] c;
    case (idx)
      3'd0: c = 8'h77;
      3'd1: c = 8'h69;
      3'd2: c = 8'h6E;
      3'd3: c = 8'h65;
      3'd4: c = 8'h2D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [CharBits-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_space(input logic [CharBits-1:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

// ===== hw/rtl/vsp_if.sv =====
interface vsp_char_if;
  logic                valid;
  logic                ready;
  vsp_pkg::char_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface vsp_result_if;
  logic                  valid;
  logic                  ready;
  vsp_pkg::result_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/vsp_digit_acc.sv =====
module vsp_digit_acc (
  input  logic [vsp_pkg::NumberBits-1:0] acc,
  input  logic [vsp_pkg::DigitBits-1:0]  digit,
  output logic [vsp_pkg::NumberBits-1:0] sum,
  output logic                           overflow
);
  import vsp_pkg::*;

  localparam int WideBits = NumberBits + 4;

  logic [WideBits-1:0] acc_wide;
  logic [WideBits-1:0] total;

  // acc * 10 + digit, built from two shifts; any carry above 64 bits is overflow.
  assign acc_wide = WideBits'(acc);
  assign total    = (acc_wide << 3) + (acc_wide << 1) + WideBits'(digit);
  assign sum      = total[NumberBits-1:0];
  assign overflow = |total[WideBits-1:NumberBits];

endmodule

// ===== hw/rtl/version_string_parser.sv =====
// Version string parser. Characters arrive one word per cycle on chars, the last one
// flagged by final_char, and the parser takes one character every clock cycle.
// Each character updates the registered parse state through one shared
// multiply-by-ten-and-add unit on the 64-bit number currently being read. One result
// word follows on result the cycle after the final character is taken, and it is held
// in an output register. While that word waits unaccepted, no further character is
// taken. When result takes it in the same cycle, the next string starts without a gap.
module version_string_parser #(
  parameter int POSITION_BITS = vsp_pkg::PositionBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  vsp_char_if.sink            chars,
  vsp_result_if.source        result
);
  import vsp_pkg::*;

  localparam int ModeBits = 4;
  localparam logic [ModeBits-1:0] MODE_FIRST  = 4'd0;
  localparam logic [ModeBits-1:0] MODE_PREFIX = 4'd1;
  localparam logic [ModeBits-1:0] MODE_MAJ0   = 4'd2;
  localparam logic [ModeBits-1:0] MODE_MAJ    = 4'd3;
  localparam logic [ModeBits-1:0] MODE_MIN0   = 4'd4;
  localparam logic [ModeBits-1:0] MODE_MIN    = 4'd5;
  localparam logic [ModeBits-1:0] MODE_PAT0   = 4'd6;
  localparam logic [ModeBits-1:0] MODE_PAT    = 4'd7;
  localparam logic [ModeBits-1:0] MODE_RC_R   = 4'd8;
  localparam logic [ModeBits-1:0] MODE_RC_C   = 4'd9;
  localparam logic [ModeBits-1:0] MODE_RC0    = 4'd10;
  localparam logic [ModeBits-1:0] MODE_RC     = 4'd11;
  localparam logic [ModeBits-1:0] MODE_WS     = 4'd12;
  localparam logic [ModeBits-1:0] MODE_DONE   = 4'd13;

  localparam int WideBits = POSITION_BITS + BuildPosBits;
  localparam logic [PrefixBits-1:0] PrefixLast = PrefixBits'(PrefixLength - 1);

  logic [ModeBits-1:0]      parse_mode, parse_mode_next;
  logic [PrefixBits-1:0]    prefix_index, prefix_index_next;
  logic [POSITION_BITS-1:0] char_position, char_position_next;
  logic [NumberBits-1:0]    major_acc, major_acc_next;
  logic [NumberBits-1:0]    minor_acc, minor_acc_next;
  logic [NumberBits-1:0]    patch_acc, patch_acc_next;
  logic [NumberBits-1:0]    candidate_acc, candidate_acc_next;
  logic [ErrorBits-1:0]     error_latch, error_latch_next;
  logic [BuildPosBits-1:0]  build_offset, build_offset_next;
  logic                     build_seen, build_seen_next;

  logic                     out_valid;
  result_word_t             out_word, out_word_next;

  logic                     accept;
  logic [CharBits-1:0]      ch;
  logic                     dig;
  logic                     spc;
  logic [NumberBits-1:0]    sel_acc;
  logic [NumberBits-1:0]    acc_sum;
  logic                     acc_ovf;
  logic [ErrorBits-1:0]     code;
  logic [WideBits-1:0]      pos_wide;

  assign accept       = chars.valid && chars.ready;
  assign chars.ready  = !out_valid || result.ready;
  assign result.valid = out_valid;
  assign result.payload = out_word;

  assign ch  = chars.payload.character;
  assign dig = is_digit(ch);
  assign spc = is_space(ch);

  // The number being read is chosen by the current mode.
  always_comb begin
    case (parse_mode)
      MODE_MIN0, MODE_MIN: sel_acc = minor_acc;
      MODE_PAT0, MODE_PAT: sel_acc = patch_acc;
      MODE_RC0, MODE_RC:   sel_acc = candidate_acc;
      default:             sel_acc = major_acc;
    endcase
  end

  vsp_digit_acc u_digit (
    .acc      (sel_acc),
    .digit    (ch[DigitBits-1:0]),
    .sum      (acc_sum),
    .overflow (acc_ovf)
  );

  assign pos_wide = WideBits'(char_position);

  always_comb begin
    parse_mode_next    = parse_mode;
    prefix_index_next  = prefix_index;
    major_acc_next     = major_acc;
    minor_acc_next     = minor_acc;
    patch_acc_next     = patch_acc;
    candidate_acc_next = candidate_acc;
    error_latch_next   = error_latch;
    build_offset_next  = build_offset;
    build_seen_next    = build_seen;

    case (parse_mode)
      MODE_FIRST: begin
        if (ch == prefix_char(3'd0)) begin
          prefix_index_next = 3'd1;
          parse_mode_next   = MODE_PREFIX;
        end else if (dig && !acc_ovf) begin
          major_acc_next  = acc_sum;
          parse_mode_next = MODE_MAJ;
        end else begin
          error_latch_next = ERR_MAJOR;
          parse_mode_next  = MODE_DONE;
        end
      end
      MODE_PREFIX: begin
        if (ch == prefix_char(prefix_index)) begin
          prefix_index_next = prefix_index + 3'd1;
          if (prefix_index == PrefixLast) begin
            parse_mode_next = MODE_MAJ0;
          end
        end else begin
          error_latch_next = ERR_MAJOR;
          parse_mode_next  = MODE_DONE;
        end
      end
      MODE_MAJ0, MODE_MAJ: begin
        if (dig && !acc_ovf) begin
          major_acc_next  = acc_sum;
          parse_mode_next = MODE_MAJ;
        end else if (dig || parse_mode == MODE_MAJ0) begin
          error_latch_next = ERR_MAJOR;
          parse_mode_next  = MODE_DONE;
        end else if (ch == CHAR_DOT) begin
          parse_mode_next = MODE_MIN0;
        end else begin
          error_latch_next = ERR_NO_DOT;
          parse_mode_next  = MODE_DONE;
        end
      end
      MODE_MIN0, MODE_MIN: begin
        if (dig && !acc_ovf) begin
          minor_acc_next  = acc_sum;
          parse_mode_next = MODE_MIN;
        end else if (dig || parse_mode == MODE_MIN0) begin
          error_latch_next = ERR_MINOR;
          parse_mode_next  = MODE_DONE;
        end else if (ch == CHAR_DOT) begin
          parse_mode_next = MODE_PAT0;
        end else if (ch == CHAR_DASH) begin
          parse_mode_next = MODE_RC_R;
        end else if (spc) begin
          parse_mode_next = MODE_WS;
        end else begin
          error_latch_next = ERR_BUILD;
          parse_mode_next  = MODE_DONE;
        end
      end
      MODE_PAT0, MODE_PAT: begin
        if (dig && !acc_ovf) begin
          patch_acc_next  = acc_sum;
          parse_mode_next = MODE_PAT;
        end else if (dig || parse_mode == MODE_PAT0) begin
          error_latch_next = ERR_PATCH;
          parse_mode_next  = MODE_DONE;
        end else if (ch == CHAR_DASH) begin
          parse_mode_next = MODE_RC_R;
        end else if (spc) begin
          parse_mode_next = MODE_WS;
        end else begin
          error_latch_next = ERR_BUILD;
          parse_mode_next  = MODE_DONE;
        end
      end
      MODE_RC_R: begin
        if (ch == CHAR_R) begin
          parse_mode_next = MODE_RC_C;
        end else begin
          error_latch_next = ERR_RC_FORMAT;
          parse_mode_next  = MODE_DONE;
        end
      end
      MODE_RC_C: begin
        if (ch == CHAR_C) begin
          parse_mode_next = MODE_RC0;
        end else begin
          error_latch_next = ERR_RC_FORMAT;
          parse_mode_next  = MODE_DONE;
        end
      end
      MODE_RC0, MODE_RC: begin
        if (dig && !acc_ovf) begin
          candidate_acc_next = acc_sum;
          parse_mode_next    = MODE_RC;
        end else if (dig || parse_mode == MODE_RC0) begin
          error_latch_next = ERR_RC_NUMBER;
          parse_mode_next  = MODE_DONE;
        end else if (spc) begin
          parse_mode_next = MODE_WS;
        end else begin
          error_latch_next = ERR_BUILD;
          parse_mode_next  = MODE_DONE;
        end
      end
      MODE_WS: begin
        if (!spc) begin
          build_seen_next   = 1'b1;
          build_offset_next = (pos_wide > WideBits'(BuildStartMax)) ?
                              BuildStartMax : pos_wide[BuildPosBits-1:0];
          parse_mode_next   = MODE_DONE;
        end
      end
      default: begin
      end
    endcase

    char_position_next = (char_position == '1) ? char_position
                                               : char_position + POSITION_BITS'(1);

    // An early end reports the unfinished field as bad, or no dot after the major.
    code = error_latch_next;
    if (code == ERR_NONE) begin
      case (parse_mode_next)
        MODE_FIRST, MODE_PREFIX, MODE_MAJ0: code = ERR_MAJOR;
        MODE_MAJ:                           code = ERR_NO_DOT;
        MODE_MIN0:                          code = ERR_MINOR;
        MODE_PAT0:                          code = ERR_PATCH;
        MODE_RC_R, MODE_RC_C:               code = ERR_RC_FORMAT;
        MODE_RC0:                           code = ERR_RC_NUMBER;
        default:                            code = ERR_NONE;
      endcase
    end

    out_word_next = '0;
    out_word_next.error_code = code;
    if (code == ERR_NONE) begin
      out_word_next.major_version    = major_acc_next;
      out_word_next.minor_version    = minor_acc_next;
      out_word_next.patch_version    = patch_acc_next;
      out_word_next.candidate_number = candidate_acc_next;
      out_word_next.has_build_text   = build_seen_next;
      out_word_next.build_start      = build_seen_next ? build_offset_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && chars.payload.final_char)) begin
      parse_mode    <= MODE_FIRST;
      prefix_index  <= '0;
      char_position <= '0;
      major_acc     <= '0;
      minor_acc     <= '0;
      patch_acc     <= '0;
      candidate_acc <= '0;
      error_latch   <= ERR_NONE;
      build_offset  <= '0;
      build_seen    <= 1'b0;
    end else if (accept) begin
      parse_mode    <= parse_mode_next;
      prefix_index  <= prefix_index_next;
      char_position <= char_position_next;
      major_acc     <= major_acc_next;
      minor_acc     <= minor_acc_next;
      patch_acc     <= patch_acc_next;
      candidate_acc <= candidate_acc_next;
      error_latch   <= error_latch_next;
      build_offset  <= build_offset_next;
      build_seen    <= build_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && chars.payload.final_char) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && chars.payload.final_char) begin
      out_word <= out_word_next;
    end
  end

endmodule
